// File: sv/length_prefix_deframer_defines.svh
// Assertion macros shared by the deframer modules.
`ifndef LENGTH_PREFIX_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIX_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LPD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/lpd_pkg.sv
// Types and constants shared by the length-prefix deframer.
package lpd_pkg;

   localparam int BYTE_W      = 8;
   localparam int SIZE_W      = 3;
   localparam int LEN_W       = 32;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_FIELD_BYTES = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BUFFER_LIMIT     = 8'd1;

   localparam logic [SIZE_W-1:0] SIZE_FIELD_RESET   = 3'd4;
   localparam logic [LEN_W-1:0]  BUFFER_LIMIT_RESET = 32'd1024;

   typedef struct packed {
      logic [SIZE_W-1:0] size_field_bytes;
      logic [LEN_W-1:0]  buffer_limit;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              msg_first;
      logic              msg_last;
      logic              oversized;
      logic              length_error;
      logic              chunk_end;
      logic              run_last;
   } rsp_item_type;

endpackage

// File: sv/lpd_interfaces.sv
// Channel interfaces of the deframer: byte input, result output and register writes.
interface lpd_req_if;
   logic                       valid;
   logic                       ready;
   logic [lpd_pkg::BYTE_W-1:0] data_byte;
   logic                       end_of_chunk;

   modport source (output valid, output data_byte, output end_of_chunk, input ready);
   modport sink (input valid, input data_byte, input end_of_chunk, output ready);
endinterface

interface lpd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lpd_pkg::BYTE_W-1:0] out_byte;
   logic                       msg_first;
   logic                       msg_last;
   logic                       oversized;
   logic                       length_error;
   logic                       chunk_end;
   logic                       run_last;

   modport source (output valid, output out_byte, output msg_first, output msg_last,
                   output oversized, output length_error, output chunk_end,
                   output run_last, input ready);
   modport sink (input valid, input out_byte, input msg_first, input msg_last,
                 input oversized, input length_error, input chunk_end,
                 input run_last, output ready);
endinterface

interface lpd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lpd_pkg::CSR_INDEX_W-1:0] reg_index;
   logic [lpd_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// File: sv/lpd_csr.sv
// Configuration registers of the deframer with their write decoder.
module lpd_csr (
   input  logic               clock,
   input  logic               reset,
   lpd_csr_if.sink            csr_chan,
   output lpd_pkg::cfg_type   cfg,
   output logic               width_written
);

   lpd_pkg::cfg_type cfg_ff;
   lpd_pkg::cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;
   assign width_written  = csr_chan.valid &&
                           (csr_chan.reg_index == lpd_pkg::REG_SIZE_FIELD_BYTES);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            lpd_pkg::REG_SIZE_FIELD_BYTES: begin
               cfg_in.size_field_bytes = csr_chan.wdata[lpd_pkg::SIZE_W-1:0];
            end
            lpd_pkg::REG_BUFFER_LIMIT: begin
               cfg_in.buffer_limit = csr_chan.wdata[lpd_pkg::LEN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_field_bytes <= lpd_pkg::SIZE_FIELD_RESET;
         cfg_ff.buffer_limit     <= lpd_pkg::BUFFER_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/lpd_core.sv
// Input register and framing state; turns one held byte into a run of results.
`include "length_prefix_deframer_defines.svh"

module lpd_core #(
   parameter int MAX_HEADER_BYTES = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   lpd_req_if.sink                 req_chan,
   input  lpd_pkg::cfg_type        cfg,
   input  logic                    width_written,
   input  logic                    load_ok,
   output logic                    load_en,
   output logic [$clog2(MAX_HEADER_BYTES+1)-1:0] load_cnt,
   output lpd_pkg::rsp_item_type   load_data [MAX_HEADER_BYTES]
);

   localparam int HIDX_W = (MAX_HEADER_BYTES > 1) ? $clog2(MAX_HEADER_BYTES) : 1;
   localparam int CNT_W  = $clog2(MAX_HEADER_BYTES + 1);

   // Input register.
   logic                       in_valid_ff;
   logic [lpd_pkg::BYTE_W-1:0] in_byte_ff;
   logic                       in_chunk_ff;

   // Framing state.
   logic [lpd_pkg::BYTE_W-1:0] hold_ff [MAX_HEADER_BYTES];
   logic [lpd_pkg::BYTE_W-1:0] hold_in [MAX_HEADER_BYTES];
   logic [lpd_pkg::SIZE_W-1:0] hc_ff, hc_in;
   logic [lpd_pkg::LEN_W-1:0]  rem_ff, rem_in;
   logic                       over_ff, over_in;

   logic [lpd_pkg::SIZE_W-1:0] w;
   logic                       width_ok;
   logic [lpd_pkg::SIZE_W-1:0] hc_inc;
   logic [lpd_pkg::LEN_W-1:0]  msg_len;
   logic [lpd_pkg::LEN_W-1:0]  w_ext;
   logic                       len_err;
   logic                       len_over;
   logic [CNT_W-1:0]           nres;
   logic                       advance;
   logic                       req_fire;

   assign w        = cfg.size_field_bytes;
   assign w_ext    = lpd_pkg::LEN_W'(w);
   assign width_ok = ((w == 3'd1) || (w == 3'd2) || (w == 3'd4)) &&
                     (int'(w) <= MAX_HEADER_BYTES);
   assign hc_inc   = hc_ff + 3'd1;

   // An item with no result moves on at once; otherwise it waits for the burst register.
   assign advance        = in_valid_ff && ((nres == '0) || load_ok);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign load_en        = advance && (nres != '0);
   assign load_cnt       = nres;

   always_comb begin
      hold_in  = hold_ff;
      hc_in    = hc_ff;
      rem_in   = rem_ff;
      over_in  = over_ff;
      nres     = '0;
      msg_len  = '0;
      len_err  = 1'b0;
      len_over = 1'b0;
      for (int i = 0; i < MAX_HEADER_BYTES; i++) begin
         load_data[i] = '0;
      end

      if (rem_ff != '0) begin
         // Body byte passes straight through.
         load_data[0].out_byte  = in_byte_ff;
         load_data[0].msg_last  = (rem_ff == 32'd1);
         load_data[0].oversized = over_ff;
         load_data[0].chunk_end = in_chunk_ff;
         load_data[0].run_last  = 1'b1;
         nres   = CNT_W'(1);
         rem_in = rem_ff - 32'd1;
         if (rem_ff == 32'd1) begin
            over_in = 1'b0;
         end
      end else if (!width_ok) begin
         // Unusable prefix width: every byte is its own failed message.
         hc_in = '0;
         load_data[0].out_byte     = in_byte_ff;
         load_data[0].msg_first    = 1'b1;
         load_data[0].msg_last     = 1'b1;
         load_data[0].length_error = 1'b1;
         load_data[0].chunk_end    = in_chunk_ff;
         load_data[0].run_last     = 1'b1;
         nres = CNT_W'(1);
      end else begin
         hold_in[hc_ff[HIDX_W-1:0]] = in_byte_ff;
         if (hc_inc < w) begin
            hc_in = hc_inc;
         end else begin
            hc_in = '0;
            for (int i = 0; i < MAX_HEADER_BYTES; i++) begin
               if (i < int'(w)) begin
                  msg_len = msg_len | (lpd_pkg::LEN_W'(hold_in[i]) << (8 * i));
               end
            end
            len_err = (msg_len < w_ext);
            if (!len_err && (msg_len > w_ext)) begin
               rem_in   = msg_len - w_ext;
               len_over = (msg_len > cfg.buffer_limit);
               over_in  = len_over;
            end
            for (int i = 0; i < MAX_HEADER_BYTES; i++) begin
               if (i < int'(w)) begin
                  load_data[i].out_byte     = hold_in[i];
                  load_data[i].msg_first    = (i == 0);
                  load_data[i].msg_last     = (i == int'(w) - 1) && (rem_in == '0);
                  load_data[i].oversized    = len_over;
                  load_data[i].length_error = len_err;
                  load_data[i].chunk_end    = (i == int'(w) - 1) && in_chunk_ff;
                  load_data[i].run_last     = (i == int'(w) - 1);
               end
            end
            nres = CNT_W'(w);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         hc_ff       <= '0;
         rem_ff      <= '0;
         over_ff     <= 1'b0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rem_ff  <= rem_in;
            over_ff <= over_in;
         end
         if (width_written) begin
            hc_ff <= '0;
         end else if (advance) begin
            hc_ff <= hc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff  <= req_chan.data_byte;
         in_chunk_ff <= req_chan.end_of_chunk;
      end
      if (advance) begin
         hold_ff <= hold_in;
      end
   end

   `LPD_ASSERT_IMPLIES(a_over_needs_body, clock, reset, rem_ff == '0, !over_ff, "oversize flag set with no body pending")
   `LPD_ASSERT_IMPLIES(a_header_count_bound, clock, reset, width_ok, hc_ff < w, "header count reached the prefix width")
   `LPD_ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !advance, in_valid_ff, "input byte lost while stalled")

endmodule

// File: sv/lpd_burst.sv
// Result register that holds one run of up to MAX_HEADER_BYTES results and sends them in turn.
`include "length_prefix_deframer_defines.svh"

module lpd_burst #(
   parameter int MAX_HEADER_BYTES = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_en,
   input  logic [$clog2(MAX_HEADER_BYTES+1)-1:0] load_cnt,
   input  lpd_pkg::rsp_item_type   load_data [MAX_HEADER_BYTES],
   output logic                    load_ok,
   lpd_rsp_if.source               rsp_chan
);

   localparam int HIDX_W = (MAX_HEADER_BYTES > 1) ? $clog2(MAX_HEADER_BYTES) : 1;
   localparam int CNT_W  = $clog2(MAX_HEADER_BYTES + 1);

   lpd_pkg::rsp_item_type data_ff [MAX_HEADER_BYTES];
   logic [CNT_W-1:0]      cnt_ff;
   logic [HIDX_W-1:0]     ptr_ff;
   logic                  take;
   logic                  at_end;
   lpd_pkg::rsp_item_type cur;

   assign cur     = data_ff[ptr_ff];
   assign at_end  = (CNT_W'(ptr_ff) + CNT_W'(1)) == cnt_ff;
   assign take    = rsp_chan.valid && rsp_chan.ready;
   assign load_ok = (cnt_ff == '0) || (take && at_end);

   assign rsp_chan.valid        = (cnt_ff != '0);
   assign rsp_chan.out_byte     = cur.out_byte;
   assign rsp_chan.msg_first    = cur.msg_first;
   assign rsp_chan.msg_last     = cur.msg_last;
   assign rsp_chan.oversized    = cur.oversized;
   assign rsp_chan.length_error = cur.length_error;
   assign rsp_chan.chunk_end    = cur.chunk_end;
   assign rsp_chan.run_last     = cur.run_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ptr_ff <= '0;
      end else if (load_en) begin
         cnt_ff <= load_cnt;
         ptr_ff <= '0;
      end else if (take && at_end) begin
         cnt_ff <= '0;
         ptr_ff <= '0;
      end else if (take) begin
         ptr_ff <= ptr_ff + HIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         data_ff <= load_data;
      end
   end

   `LPD_ASSERT_IMPLIES(a_run_last_at_end, clock, reset, rsp_chan.valid && rsp_chan.run_last, at_end, "run ended before its last entry")
   `LPD_ASSERT_IMPLIES(a_load_when_free, clock, reset, load_en, load_ok, "run loaded over results not yet sent")

endmodule

// File: sv/length_prefix_deframer.sv
// Path: a byte accepted on req passes the input register, then the result register, to rsp.
// Throughput: one byte per cycle for held header bytes, and for body bytes while rsp is ready;
// the byte that completes a header releases size_field_bytes results, which hold the result
// register until all are sent while one further byte waits in the input register.
// Reset: synchronous, active high; clears framing state, empties both registers and
// restores size_field_bytes to 4 and buffer_limit to 1024.
module length_prefix_deframer #(
   parameter int MAX_HEADER_BYTES = 4
) (
   input  logic      clock,
   input  logic      reset,
   lpd_req_if.sink   req_chan,
   lpd_rsp_if.source rsp_chan,
   lpd_csr_if.sink   csr_chan
);

   localparam int CNT_W = $clog2(MAX_HEADER_BYTES + 1);

   // Current configuration and a pulse that marks a write of the prefix width. Such a
   // write drops any partly received header, as the framing restarts at the new width.
   lpd_pkg::cfg_type cfg;
   logic             width_written;

   // Hand-off of one run of results from the framing logic to the result register.
   // The framing logic only loads a run when the result register is empty or is
   // sending its final entry in this cycle, so no result is ever overwritten.
   logic                  load_en;
   logic                  load_ok;
   logic [CNT_W-1:0]      load_cnt;
   lpd_pkg::rsp_item_type load_data [MAX_HEADER_BYTES];

   // Register file for the prefix width and the buffer limit.
   lpd_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_chan      (csr_chan),
      .cfg           (cfg),
      .width_written (width_written)
   );

   // Input register and framing state. Header bytes are collected until the whole length
   // field is in, then released together with first/last, oversize and error flags; body
   // bytes pass through one at a time while the remaining count runs down.
   lpd_core #(
      .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .cfg           (cfg),
      .width_written (width_written),
      .load_ok       (load_ok),
      .load_en       (load_en),
      .load_cnt      (load_cnt),
      .load_data     (load_data)
   );

   // Result register: presents the run one entry per transaction on the rsp channel.
   lpd_burst #(
      .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
   ) u_burst (
      .clock     (clock),
      .reset     (reset),
      .load_en   (load_en),
      .load_cnt  (load_cnt),
      .load_data (load_data),
      .load_ok   (load_ok),
      .rsp_chan  (rsp_chan)
   );

endmodule
